// ----- sv/bse_pkg.sv -----
package bse_pkg;

  // Field widths
  localparam int OP_W     = 2;
  localparam int MV_W     = 16;
  localparam int TIME_W   = 32;
  localparam int STATE_W  = 3;
  localparam int SOC_W    = 7;
  localparam int CELL_W   = 5;
  localparam int SETTLE_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Curve geometry
  localparam int CURVE_POINTS = 11;
  localparam int K_W          = $clog2(CURVE_POINTS + 1);
  localparam int PT_W         = 12;
  localparam int SOC_STEP     = 100 / (CURVE_POINTS - 1);
  localparam int SOC_TOP      = 100;
  localparam int ACTIVE_SETTLE_S = 30;

  // Shift/subtract divider
  localparam int DIV_W   = 16;
  localparam int REM_W   = 8;
  localparam int CNT_W   = 5;
  localparam int SPAN_W  = 8;   // widest gap between neighboring points fits here
  localparam int FNUM_W  = 11;  // SOC_STEP * gap
  localparam int FRAC_W  = 4;   // interpolated part, 0..SOC_STEP

  typedef enum logic [OP_W-1:0] {
    OP_SET_STATE = 2'd0,
    OP_SAMPLE    = 2'd1,
    OP_RESET_EST = 2'd2,
    OP_NOP       = 2'd3
  } op_t;

  typedef enum logic [STATE_W-1:0] {
    ST_IDLE        = 3'd0,
    ST_CHARGING    = 3'd1,
    ST_DISCHARGING = 3'd2,
    ST_EMPTY       = 3'd3,
    ST_FULL        = 3'd4,
    ST_DISABLED    = 3'd5,
    ST_INVALID     = 3'd6
  } bstate_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CELL_COUNT = 2'd0,
    CFG_SETTLE     = 2'd1,
    CFG_MGMT_EN    = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CURVE_IDLE,
    CURVE_CHARGE,
    CURVE_DISCHARGE
  } curve_sel_t;

  localparam logic [CELL_W-1:0]   CELL_COUNT_RST = 5'd4;
  localparam logic [SETTLE_W-1:0] SETTLE_RST     = 16'd300;

  localparam logic [PT_W-1:0] CURVE_DIS_MV [CURVE_POINTS] = '{
    12'd3100, 12'd3120, 12'd3160, 12'd3190, 12'd3200, 12'd3210,
    12'd3220, 12'd3240, 12'd3260, 12'd3270, 12'd3340};
  localparam logic [PT_W-1:0] CURVE_CHG_MV [CURVE_POINTS] = '{
    12'd3120, 12'd3315, 12'd3355, 12'd3375, 12'd3390, 12'd3400,
    12'd3415, 12'd3430, 12'd3445, 12'd3455, 12'd3470};
  localparam logic [PT_W-1:0] CURVE_IDLE_MV [CURVE_POINTS] = '{
    12'd3110, 12'd3223, 12'd3263, 12'd3295, 12'd3308, 12'd3318,
    12'd3330, 12'd3343, 12'd3355, 12'd3363, 12'd3405};

  // Point k of the selected curve; past the end reads as zero
  function automatic logic [PT_W-1:0] curve_point(curve_sel_t sel, logic [K_W-1:0] k);
    logic [PT_W-1:0] pt;
    pt = '0;
    if (k < K_W'(CURVE_POINTS)) begin
      case (sel)
        CURVE_CHARGE:    pt = CURVE_CHG_MV[k];
        CURVE_DISCHARGE: pt = CURVE_DIS_MV[k];
        default:         pt = CURVE_IDLE_MV[k];
      endcase
    end
    return pt;
  endfunction

  // Microcode
  localparam int STEP_W = 3;

  typedef enum logic [2:0] {
    ACT_ELAPSED,
    ACT_DISPATCH,
    ACT_DIV,
    ACT_SEARCH,
    ACT_PREP,
    ACT_FRAC,
    ACT_FINISH
  } act_t;

  typedef enum logic [2:0] {
    JMP_NONE,
    JMP_SKIP,
    JMP_CNT,
    JMP_SEARCH,
    JMP_EDGE,
    JMP_END
  } jmp_t;

  typedef struct packed {
    act_t              act;
    jmp_t              jmp;
    logic [STEP_W-1:0] target;
  } uword_t;

  localparam logic [STEP_W-1:0] STEP_FINISH = 3'd7;

  function automatic uword_t ucode(logic [STEP_W-1:0] step);
    uword_t w;
    unique case (step)
      3'd0:    w = '{act: ACT_ELAPSED,  jmp: JMP_NONE,   target: 3'd0};
      3'd1:    w = '{act: ACT_DISPATCH, jmp: JMP_SKIP,   target: STEP_FINISH};
      3'd2:    w = '{act: ACT_DIV,      jmp: JMP_CNT,    target: 3'd2};
      3'd3:    w = '{act: ACT_SEARCH,   jmp: JMP_SEARCH, target: 3'd3};
      3'd4:    w = '{act: ACT_PREP,     jmp: JMP_EDGE,   target: STEP_FINISH};
      3'd5:    w = '{act: ACT_DIV,      jmp: JMP_CNT,    target: 3'd5};
      3'd6:    w = '{act: ACT_FRAC,     jmp: JMP_NONE,   target: 3'd0};
      default: w = '{act: ACT_FINISH,   jmp: JMP_END,    target: 3'd0};
    endcase
    return w;
  endfunction

endpackage

// ----- sv/bse_if.sv -----
interface bse_in_if;
  logic                           valid;
  logic                           ready;
  logic [bse_pkg::OP_W-1:0]       op;
  logic [bse_pkg::MV_W-1:0]       pack_mv;
  logic [bse_pkg::TIME_W-1:0]     uptime_s;
  logic [bse_pkg::STATE_W-1:0]    new_state;
  modport source (output valid, op, pack_mv, uptime_s, new_state, input ready);
  modport sink   (input valid, op, pack_mv, uptime_s, new_state, output ready);
endinterface

interface bse_out_if;
  logic                           valid;
  logic                           ready;
  logic [bse_pkg::SOC_W-1:0]      soc_percent;
  logic [bse_pkg::STATE_W-1:0]    batt_mode;
  modport source (output valid, soc_percent, batt_mode, input ready);
  modport sink   (input valid, soc_percent, batt_mode, output ready);
endinterface

interface bse_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bse_pkg::CFG_IDX_W-1:0]   index;
  logic [bse_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/battery_soc_estimator.sv -----
// Sequence: elapsed time, dispatch; requests needing no curve lookup then
//   finish, others run a 16-bit pack/cell divide, the curve search, setup
//   and an 11-bit interpolation divide (not at curve edges) on the same divider.
// Flow: one request at a time; the next is taken the cycle after a result is
//   loaded, while the result register waits.
// Reset (rst_n low, synchronous): state idle, estimate 0, change time 0,
//   cell count 4, settle time 300 s; no result pending.
module battery_soc_estimator (
  input logic      clk,
  input logic      rst_n,
  bse_in_if.sink   in_if,
  bse_out_if.source out_if,
  bse_cfg_if.sink  cfg_if
);

  // Sequencer
  logic                           busy_r;
  logic [bse_pkg::STEP_W-1:0]     step_r;
  bse_pkg::uword_t                uw;

  // Captured request
  bse_pkg::op_t                   op_r;
  logic [bse_pkg::MV_W-1:0]       pack_r;
  logic [bse_pkg::TIME_W-1:0]     uptime_r;
  logic [bse_pkg::STATE_W-1:0]    req_r;

  // Datapath
  logic [bse_pkg::TIME_W-1:0]     elapsed_r;
  logic                           skip_r;
  logic [bse_pkg::DIV_W-1:0]      num_r;
  logic [bse_pkg::REM_W-1:0]      rem_r;
  logic [bse_pkg::REM_W-1:0]      den_r;
  logic [bse_pkg::CNT_W-1:0]      cnt_r;
  logic [bse_pkg::K_W-1:0]        k_r;
  bse_pkg::curve_sel_t            curve_r;
  logic [bse_pkg::SOC_W-1:0]      base_r;
  logic [bse_pkg::SOC_W-1:0]      fresh_r;

  // Architectural state
  bse_pkg::bstate_t               mode_r;
  logic [bse_pkg::SOC_W-1:0]      est_r;
  logic [bse_pkg::TIME_W-1:0]     last_r;
  logic [bse_pkg::CELL_W-1:0]     cell_r;
  logic [bse_pkg::SETTLE_W-1:0]   settle_r;

  // Result register
  logic                           out_valid_r;
  logic [bse_pkg::SOC_W-1:0]      out_soc_r;
  bse_pkg::bstate_t               out_state_r;

  assign uw = bse_pkg::ucode(step_r);

  assign in_if.ready          = !busy_r;
  assign cfg_if.ready         = !busy_r;
  assign out_if.valid         = out_valid_r;
  assign out_if.soc_percent   = out_soc_r;
  assign out_if.batt_mode     = out_state_r;

  logic out_free;
  assign out_free = !out_valid_r || out_if.ready;

  // Elapsed time since the last state change, zero when uptime is behind
  logic [bse_pkg::TIME_W:0] elapsed_diff;
  assign elapsed_diff = {1'b0, uptime_r} - {1'b0, last_r};

  // Dispatch: settle check and whether a curve lookup is needed
  logic [bse_pkg::SETTLE_W-1:0] wait_s;
  logic                         settled;
  logic                         lookup_mode;
  logic                         skip;
  logic [bse_pkg::CELL_W-1:0]   cells;
  bse_pkg::curve_sel_t          curve_sel;

  always_comb begin
    wait_s = (mode_r == bse_pkg::ST_IDLE || mode_r == bse_pkg::ST_EMPTY)
             ? settle_r : bse_pkg::SETTLE_W'(bse_pkg::ACTIVE_SETTLE_S);
    settled = elapsed_r > {{(bse_pkg::TIME_W - bse_pkg::SETTLE_W){1'b0}}, wait_s};
    lookup_mode = (mode_r == bse_pkg::ST_IDLE) || (mode_r == bse_pkg::ST_EMPTY) ||
                  (mode_r == bse_pkg::ST_FULL) || (mode_r == bse_pkg::ST_CHARGING) ||
                  (mode_r == bse_pkg::ST_DISCHARGING);
    skip = !lookup_mode ||
           !((op_r == bse_pkg::OP_SAMPLE && settled) || op_r == bse_pkg::OP_RESET_EST);
    cells = (cell_r == '0) ? bse_pkg::CELL_W'(1) : cell_r;
    case (mode_r)
      bse_pkg::ST_CHARGING:    curve_sel = bse_pkg::CURVE_CHARGE;
      bse_pkg::ST_DISCHARGING: curve_sel = bse_pkg::CURVE_DISCHARGE;
      default:                 curve_sel = bse_pkg::CURVE_IDLE;
    endcase
  end

  // One restoring divide step: one quotient bit per cycle
  logic [bse_pkg::REM_W:0]     rem_sh;
  logic                        rem_ge;
  logic [bse_pkg::REM_W-1:0]   rem_new;
  always_comb begin
    rem_sh  = {rem_r, num_r[bse_pkg::DIV_W-1]};
    rem_ge  = rem_sh >= {1'b0, den_r};
    rem_new = rem_ge ? bse_pkg::REM_W'(rem_sh - {1'b0, den_r})
                     : rem_sh[bse_pkg::REM_W-1:0];
  end

  // Curve search: first point at or above the per-cell voltage
  logic [bse_pkg::PT_W-1:0] pt_k;
  logic                     search_more;
  always_comb begin
    pt_k = bse_pkg::curve_point(curve_r, k_r);
    search_more = (k_r < bse_pkg::K_W'(bse_pkg::CURVE_POINTS)) &&
                  ({{(bse_pkg::DIV_W - bse_pkg::PT_W){1'b0}}, pt_k} < num_r);
  end

  // Interpolation setup between points k-1 and k
  logic                          edge_case;
  logic [bse_pkg::K_W-1:0]       k_lo;
  logic [bse_pkg::PT_W-1:0]      pt_lo;
  logic [bse_pkg::SPAN_W-1:0]    span;
  logic [bse_pkg::SPAN_W-1:0]    offs;
  logic [bse_pkg::FNUM_W-1:0]    fnum;
  always_comb begin
    edge_case = (k_r == '0) || (k_r >= bse_pkg::K_W'(bse_pkg::CURVE_POINTS));
    k_lo  = k_r - bse_pkg::K_W'(1);
    pt_lo = bse_pkg::curve_point(curve_r, k_lo);
    span  = bse_pkg::SPAN_W'(pt_k - pt_lo);
    offs  = bse_pkg::SPAN_W'(num_r[bse_pkg::PT_W-1:0] - pt_lo);
    fnum  = bse_pkg::FNUM_W'(offs) * bse_pkg::FNUM_W'(bse_pkg::SOC_STEP);
  end

  // Interpolated value
  logic [bse_pkg::SOC_W-1:0] frac_sum;
  assign frac_sum = base_r + bse_pkg::SOC_W'(num_r[bse_pkg::FRAC_W-1:0]);

  // Final state and estimate update
  bse_pkg::bstate_t            mode_nxt;
  logic [bse_pkg::SOC_W-1:0]   est_nxt;
  logic [bse_pkg::TIME_W-1:0]  last_nxt;
  always_comb begin
    mode_nxt = mode_r;
    est_nxt  = est_r;
    last_nxt = last_r;
    case (op_r)
      bse_pkg::OP_SET_STATE: begin
        if (mode_r != bse_pkg::ST_DISABLED) begin
          mode_nxt = (req_r > bse_pkg::ST_INVALID) ? bse_pkg::ST_INVALID
                                                   : bse_pkg::bstate_t'(req_r);
          last_nxt = uptime_r;
        end
      end
      bse_pkg::OP_SAMPLE: begin
        if (!skip_r) begin
          case (mode_r)
            bse_pkg::ST_CHARGING:    if (fresh_r > est_r) est_nxt = fresh_r;
            bse_pkg::ST_DISCHARGING: if (fresh_r < est_r) est_nxt = fresh_r;
            default:                 est_nxt = fresh_r;
          endcase
        end
      end
      bse_pkg::OP_RESET_EST: begin
        if (!skip_r) est_nxt = fresh_r;
        if (mode_r == bse_pkg::ST_EMPTY || mode_r == bse_pkg::ST_FULL) begin
          mode_nxt = bse_pkg::ST_IDLE;
          last_nxt = uptime_r;
        end
      end
      default: ;
    endcase
  end

  // Jump decision
  logic                       jump;
  logic                       hold;
  always_comb begin
    hold = 1'b0;
    case (uw.jmp)
      bse_pkg::JMP_SKIP:   jump = skip;
      bse_pkg::JMP_CNT:    jump = cnt_r != bse_pkg::CNT_W'(1);
      bse_pkg::JMP_SEARCH: jump = search_more;
      bse_pkg::JMP_EDGE:   jump = edge_case;
      bse_pkg::JMP_END: begin
        jump = 1'b1;
        hold = !out_free;
      end
      default:             jump = 1'b0;
    endcase
  end

  // Last step of a request goes ahead this cycle
  logic finish_go;
  assign finish_go = busy_r && !hold && (uw.act == bse_pkg::ACT_FINISH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      mode_r      <= bse_pkg::ST_IDLE;
      est_r       <= '0;
      last_r      <= '0;
      cell_r      <= bse_pkg::CELL_COUNT_RST;
      settle_r    <= bse_pkg::SETTLE_RST;
    end else begin
      // Result register: loads at the end of a request, drains on accept
      if (finish_go) out_valid_r <= 1'b1;
      else if (out_valid_r && out_if.ready) out_valid_r <= 1'b0;

      if (!busy_r) begin
        if (in_if.valid) begin
          busy_r   <= 1'b1;
          step_r   <= '0;
          op_r     <= bse_pkg::op_t'(in_if.op);
          pack_r   <= in_if.pack_mv;
          uptime_r <= in_if.uptime_s;
          req_r    <= in_if.new_state;
        end
      end else if (!hold) begin
        step_r <= jump ? uw.target : step_r + bse_pkg::STEP_W'(1);

        unique case (uw.act)
          bse_pkg::ACT_ELAPSED: begin
            elapsed_r <= elapsed_diff[bse_pkg::TIME_W] ? '0
                                                      : elapsed_diff[bse_pkg::TIME_W-1:0];
          end
          bse_pkg::ACT_DISPATCH: begin
            skip_r  <= skip;
            num_r   <= pack_r;
            den_r   <= bse_pkg::REM_W'(cells);
            rem_r   <= '0;
            cnt_r   <= bse_pkg::CNT_W'(bse_pkg::DIV_W);
            k_r     <= '0;
            curve_r <= curve_sel;
          end
          bse_pkg::ACT_DIV: begin
            rem_r <= rem_new;
            num_r <= {num_r[bse_pkg::DIV_W-2:0], rem_ge};
            cnt_r <= cnt_r - bse_pkg::CNT_W'(1);
          end
          bse_pkg::ACT_SEARCH: begin
            if (search_more) k_r <= k_r + bse_pkg::K_W'(1);
          end
          bse_pkg::ACT_PREP: begin
            if (k_r == '0) fresh_r <= '0;
            else           fresh_r <= bse_pkg::SOC_W'(bse_pkg::SOC_TOP);
            // Numerator left-aligned so the divider yields FNUM_W quotient bits
            num_r  <= {fnum, {(bse_pkg::DIV_W - bse_pkg::FNUM_W){1'b0}}};
            den_r  <= bse_pkg::REM_W'(span);
            rem_r  <= '0;
            cnt_r  <= bse_pkg::CNT_W'(bse_pkg::FNUM_W);
            base_r <= bse_pkg::SOC_W'(k_lo) * bse_pkg::SOC_W'(bse_pkg::SOC_STEP);
          end
          bse_pkg::ACT_FRAC: begin
            fresh_r <= (frac_sum > bse_pkg::SOC_W'(bse_pkg::SOC_TOP))
                       ? bse_pkg::SOC_W'(bse_pkg::SOC_TOP) : frac_sum;
          end
          bse_pkg::ACT_FINISH: begin
            mode_r      <= mode_nxt;
            est_r       <= est_nxt;
            last_r      <= last_nxt;
            out_soc_r   <= est_nxt;
            out_state_r <= mode_nxt;
            busy_r      <= 1'b0;
          end
          default: ;
        endcase
      end

      // Register writes, only while no request is in flight
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          bse_pkg::CFG_CELL_COUNT: cell_r   <= cfg_if.data[bse_pkg::CELL_W-1:0];
          bse_pkg::CFG_SETTLE:     settle_r <= cfg_if.data[bse_pkg::SETTLE_W-1:0];
          bse_pkg::CFG_MGMT_EN:    if (!cfg_if.data[0]) mode_r <= bse_pkg::ST_DISABLED;
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- sv/bse_checker.sv -----
module bse_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [bse_pkg::SOC_W-1:0]     soc_percent,
  input logic [bse_pkg::STATE_W-1:0]   batt_mode
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(soc_percent) && $stable(batt_mode))
    else $error("result changed while stalled");

  // One request at a time: taking a request closes the input
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // Estimate and state stay in range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> soc_percent <= bse_pkg::SOC_W'(100) &&
                  batt_mode != bse_pkg::STATE_W'(7))
    else $error("result out of range");

  // Nothing pending after reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind battery_soc_estimator bse_checker u_bse_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_if.valid),
  .in_ready      (in_if.ready),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .soc_percent   (out_if.soc_percent),
  .batt_mode     (out_if.batt_mode)
);
